/* design/radix2_fft_assert.svh */
// Assertion macros used by the checker file of the radix-2 FFT.
`ifndef RADIX2_FFT_ASSERT_SVH
`define RADIX2_FFT_ASSERT_SVH

// Clocked implication, disabled while reset is asserted.
`define R2FFT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold at a clock edge outside reset.
`define R2FFT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/r2fft_pkg.sv */
// Shared types, constants and functions of the radix-2 FFT.
package r2fft_pkg;

    localparam int MAX_LOG2_POINTS = 6;
    localparam int SAMPLE_BITS     = 16;
    localparam int BIN_BITS        = SAMPLE_BITS + MAX_LOG2_POINTS + 1;
    localparam int ADDR_BITS       = MAX_LOG2_POINTS;
    localparam int DEPTH           = 1 << ADDR_BITS;
    localparam int CNT_BITS        = ADDR_BITS + 1;
    localparam int LG_BITS         = 3;
    localparam int TW_BITS         = 17;
    localparam int TW_IDX_BITS     = ADDR_BITS - 1;
    localparam int PROD_BITS       = TW_BITS + BIN_BITS;
    localparam int ACC_BITS        = PROD_BITS + 1;
    localparam int T_BITS          = ACC_BITS - 15;
    localparam int SUM_BITS        = T_BITS + 1;
    localparam int WORD_BITS       = 2 * BIN_BITS;

    typedef logic signed [BIN_BITS-1:0] bin_t;
    typedef logic signed [TW_BITS-1:0]  tw_t;
    typedef logic signed [SUM_BITS-1:0] sum_t;

    typedef enum logic [1:0] {
        MUL_WR_BR,
        MUL_WI_BI,
        MUL_WR_BI,
        MUL_WI_BR
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_SET_RE,
        ACC_SUB_RE,
        ACC_SET_IM,
        ACC_ADD_IM
    } acc_op_t;

    typedef struct packed {
        logic                   cap_b;
        logic                   cap_a;
        mul_sel_t               mul_sel;
        acc_op_t                acc_op;
        logic [TW_IDX_BITS-1:0] tw_idx;
        logic                   inverse;
    } bfly_ctl_t;

    typedef enum logic {
        REG_INVERSE_MODE = 1'b0,
        REG_LOG2_POINTS  = 1'b1
    } cfg_reg_t;

    // Cosine over the first quarter turn of a 64-point circle, Q2.15.
    function automatic tw_t quarter_cos(input logic [4:0] k);
        tw_t v;
        case (k)
            5'd0:    v = 17'sd32768;
            5'd1:    v = 17'sd32610;
            5'd2:    v = 17'sd32138;
            5'd3:    v = 17'sd31357;
            5'd4:    v = 17'sd30274;
            5'd5:    v = 17'sd28899;
            5'd6:    v = 17'sd27246;
            5'd7:    v = 17'sd25330;
            5'd8:    v = 17'sd23170;
            5'd9:    v = 17'sd20788;
            5'd10:   v = 17'sd18205;
            5'd11:   v = 17'sd15447;
            5'd12:   v = 17'sd12540;
            5'd13:   v = 17'sd9512;
            5'd14:   v = 17'sd6393;
            5'd15:   v = 17'sd3212;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    function automatic tw_t tw_cos(input logic [TW_IDX_BITS-1:0] k);
        logic [TW_IDX_BITS-1:0] mirror;
        mirror = TW_IDX_BITS'(0) - k;
        return (k <= 5'd16) ? quarter_cos(k) : -quarter_cos(mirror);
    endfunction

    function automatic tw_t tw_sin(input logic [TW_IDX_BITS-1:0] k);
        return (k <= 5'd16) ? quarter_cos(5'd16 - k) : quarter_cos(k - 5'd16);
    endfunction

    function automatic bin_t saturate(input sum_t v);
        sum_t hi;
        sum_t lo;
        hi = sum_t'({1'b0, {(BIN_BITS-1){1'b1}}});
        lo = -hi - sum_t'(1);
        if (v > hi)
            return bin_t'(hi);
        else if (v < lo)
            return bin_t'(lo);
        else
            return bin_t'(v);
    endfunction

    // Reverses the low lg bits of i.
    function automatic logic [ADDR_BITS-1:0] bit_reverse(input logic [CNT_BITS-1:0] i,
                                                         input logic [LG_BITS-1:0] lg);
        logic [ADDR_BITS-1:0] r;
        for (int b = 0; b < ADDR_BITS; b++)
        begin
            r[ADDR_BITS-1-b] = i[b];
        end
        return r >> (LG_BITS'(ADDR_BITS) - lg);
    endfunction

endpackage

/* design/r2fft_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module r2fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* design/r2fft_bfly.sv */
// Shared butterfly datapath: one multiplier, accumulators, round and saturate.
module r2fft_bfly (
    input  logic                 clk,
    input  r2fft_pkg::bfly_ctl_t ctl,
    input  r2fft_pkg::bin_t      rd_re,
    input  r2fft_pkg::bin_t      rd_im,
    output r2fft_pkg::bin_t      sum_re,
    output r2fft_pkg::bin_t      sum_im,
    output r2fft_pkg::bin_t      dif_re,
    output r2fft_pkg::bin_t      dif_im
);
    import r2fft_pkg::*;

    bin_t br_reg, bi_reg, ar_reg, ai_reg;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic signed [ACC_BITS-1:0]  acc_re_reg, acc_im_reg;
    logic signed [ACC_BITS-1:0]  rnd_re, rnd_im;
    logic signed [T_BITS-1:0]    t_re, t_im;
    tw_t  wr, ws, wi, mul_a;
    bin_t mul_b;

    assign wr = tw_cos(ctl.tw_idx);
    assign ws = tw_sin(ctl.tw_idx);
    assign wi = ctl.inverse ? ws : -ws;

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_WR_BR: begin mul_a = wr; mul_b = br_reg; end
            MUL_WI_BI: begin mul_a = wi; mul_b = bi_reg; end
            MUL_WR_BI: begin mul_a = wr; mul_b = bi_reg; end
            MUL_WI_BR: begin mul_a = wi; mul_b = br_reg; end
            default:   begin mul_a = wr; mul_b = br_reg; end
        endcase
    end

    assign prod_next = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl.cap_b)
        begin
            br_reg <= rd_re;
            bi_reg <= rd_im;
        end
        if (ctl.cap_a)
        begin
            ar_reg <= rd_re;
            ai_reg <= rd_im;
        end
        case (ctl.acc_op)
            ACC_SET_RE: acc_re_reg <= ACC_BITS'(prod_reg);
            ACC_SUB_RE: acc_re_reg <= acc_re_reg - ACC_BITS'(prod_reg);
            ACC_SET_IM: acc_im_reg <= ACC_BITS'(prod_reg);
            ACC_ADD_IM: acc_im_reg <= acc_im_reg + ACC_BITS'(prod_reg);
            default:    ;
        endcase
    end

    // Round half up at bit 15, then keep the integer part.
    assign rnd_re = acc_re_reg + ACC_BITS'(16384);
    assign rnd_im = acc_im_reg + ACC_BITS'(16384);
    assign t_re   = rnd_re[ACC_BITS-1:15];
    assign t_im   = rnd_im[ACC_BITS-1:15];

    assign sum_re = saturate(SUM_BITS'(ar_reg) + SUM_BITS'(t_re));
    assign sum_im = saturate(SUM_BITS'(ai_reg) + SUM_BITS'(t_im));
    assign dif_re = saturate(SUM_BITS'(ar_reg) - SUM_BITS'(t_re));
    assign dif_im = saturate(SUM_BITS'(ai_reg) - SUM_BITS'(t_im));

endmodule

/* design/radix2_fft.sv */
// Top level of the iterative radix-2 decimation-in-time FFT.
//
// The block takes complex samples as words on the s_ side, storing each at
// the bit-reversed address of its arrival number, one word per cycle. The
// word that carries tlast closes the frame: positions not yet loaded are
// zeroed at one per cycle, samples past the transform length are dropped,
// and s_tready stays low until all bins have left. The transform runs
// in place in a 64-entry work RAM through one shared butterfly unit built
// around a single 17x23 multiplier; each butterfly makes two RAM reads,
// four multiplies and two RAM writes, and a transform of N points runs
// (N/2) * log2(N) butterflies after the zero fill. Bins then leave in natural
// order on the m_ side, each after the one before it is taken, with
// tlast on bin N-1. In inverse mode twiddles take the positive sine and each
// bin is divided by N with rounding half up on its way out. Butterfly
// results saturate to 23 bits. Configuration writes take effect at once and
// must be made between frames or between samples; the transform length is
// taken as it stands when the closing sample arrives.
module radix2_fft (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_re [15:0], sample_im [31:16]
    input  logic        s_tlast,   // last_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bin_re [22:0], bin_im [45:23], bin_index [51:46], zeros
    output logic        m_tlast    // last_bin
);
    import r2fft_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD, S_PAD, S_RDB, S_RDA, S_M0, S_M1, S_M2, S_M3, S_M4,
        S_WA, S_WB, S_ORD, S_OCAP, S_OWAIT
    } state_t;

    state_t               state_reg;
    logic                 inverse_reg;
    logic [LG_BITS-1:0]   log2_reg;
    logic [LG_BITS-1:0]   lg_reg;
    logic [LG_BITS-1:0]   stage_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [ADDR_BITS-2:0] bf_reg;
    logic [ADDR_BITS-1:0] k_reg;
    logic [DEPTH-1:0]     valid_reg;
    logic                 rvalid_reg;
    logic                 out_valid_reg;
    bin_t                 out_re_reg, out_im_reg;
    logic [ADDR_BITS-1:0] out_idx_reg;
    logic                 out_last_reg;

    logic [LG_BITS-1:0]   eff_lg;
    logic [CNT_BITS-1:0]  n_cur, n_run;
    logic [ADDR_BITS-1:0] half, lo_mask, jj, addr_a, addr_b;
    logic [ADDR_BITS-1:0] tw_full;
    logic                 we;
    logic [ADDR_BITS-1:0] waddr, raddr;
    logic [WORD_BITS-1:0] wdata, rdata;
    bin_t                 rd_re, rd_im, sum_re, sum_im, dif_re, dif_im;
    bin_t                 samp_re, samp_im;
    bfly_ctl_t            ctl;
    logic                 accept_in, accept_out, last_bf;
    logic signed [BIN_BITS:0] scale_re, scale_im, rnd_bias;

    // Out-of-range lengths are clamped to the supported range.
    assign eff_lg = (log2_reg == '0) ? LG_BITS'(1)
                  : (log2_reg > LG_BITS'(MAX_LOG2_POINTS)) ? LG_BITS'(MAX_LOG2_POINTS)
                  : log2_reg;
    assign n_cur  = CNT_BITS'(1) << eff_lg;
    assign n_run  = CNT_BITS'(1) << lg_reg;

    // Butterfly addressing for butterfly bf_reg of stage stage_reg.
    assign half    = ADDR_BITS'(1) << (stage_reg - LG_BITS'(1));
    assign lo_mask = half - ADDR_BITS'(1);
    assign jj      = ADDR_BITS'(bf_reg) & lo_mask;
    assign addr_a  = ((ADDR_BITS'(bf_reg) & ~lo_mask) << 1) | jj;
    assign addr_b  = addr_a | half;
    assign tw_full = jj << (LG_BITS'(ADDR_BITS) - stage_reg);
    assign last_bf = (CNT_BITS'(bf_reg) == ((n_run >> 1) - CNT_BITS'(1)));

    assign samp_re = BIN_BITS'($signed(s_tdata[15:0]));
    assign samp_im = BIN_BITS'($signed(s_tdata[31:16]));

    assign s_tready   = (state_reg == S_LOAD);
    assign accept_in  = s_tvalid && s_tready;
    assign accept_out = out_valid_reg && m_tready;

    // Entries never written since reset read as zero.
    assign rd_re = rvalid_reg ? bin_t'(rdata[BIN_BITS-1:0]) : '0;
    assign rd_im = rvalid_reg ? bin_t'(rdata[WORD_BITS-1:BIN_BITS]) : '0;

    always_comb
    begin
        we    = 1'b0;
        waddr = addr_a;
        wdata = {sum_im, sum_re};
        raddr = addr_b;
        case (state_reg)
            S_LOAD:
            begin
                we    = accept_in && (cnt_reg < n_cur);
                waddr = bit_reverse(cnt_reg, eff_lg);
                wdata = {samp_im, samp_re};
            end
            S_PAD:
            begin
                we    = (cnt_reg < n_run);
                waddr = bit_reverse(cnt_reg, lg_reg);
                wdata = '0;
            end
            S_RDA:   raddr = addr_a;
            S_WA:    we = 1'b1;
            S_WB:
            begin
                we    = 1'b1;
                waddr = addr_b;
                wdata = {dif_im, dif_re};
            end
            S_ORD:   raddr = k_reg;
            // In inverse mode the scaled bin goes back into the work RAM, so an
            // entry that a later frame leaves unwritten holds the scaled value.
            S_OCAP:
            begin
                we    = inverse_reg;
                waddr = k_reg;
                wdata = {bin_t'(scale_im), bin_t'(scale_re)};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        ctl.cap_b   = (state_reg == S_RDA);
        ctl.cap_a   = (state_reg == S_M0);
        ctl.tw_idx  = tw_full[TW_IDX_BITS-1:0];
        ctl.inverse = inverse_reg;
        ctl.mul_sel = MUL_WR_BR;
        ctl.acc_op  = ACC_HOLD;
        case (state_reg)
            S_M1:    begin ctl.mul_sel = MUL_WI_BI; ctl.acc_op = ACC_SET_RE; end
            S_M2:    begin ctl.mul_sel = MUL_WR_BI; ctl.acc_op = ACC_SUB_RE; end
            S_M3:    begin ctl.mul_sel = MUL_WI_BR; ctl.acc_op = ACC_SET_IM; end
            S_M4:    ctl.acc_op = ACC_ADD_IM;
            default: ;
        endcase
    end

    // Inverse scaling: add half of N, then arithmetic shift by log2 N.
    assign rnd_bias = (BIN_BITS+1)'(1) << (lg_reg - LG_BITS'(1));
    assign scale_re = ((BIN_BITS+1)'(rd_re) + rnd_bias) >>> lg_reg;
    assign scale_im = ((BIN_BITS+1)'(rd_im) + rnd_bias) >>> lg_reg;

    r2fft_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    r2fft_bfly u_bfly (
        .clk    (clk),
        .ctl    (ctl),
        .rd_re  (rd_re),
        .rd_im  (rd_im),
        .sum_re (sum_re),
        .sum_im (sum_im),
        .dif_re (dif_re),
        .dif_im (dif_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            inverse_reg   <= 1'b0;
            log2_reg      <= LG_BITS'(MAX_LOG2_POINTS);
            lg_reg        <= LG_BITS'(MAX_LOG2_POINTS);
            stage_reg     <= LG_BITS'(1);
            cnt_reg       <= '0;
            bf_reg        <= '0;
            k_reg         <= '0;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_re_reg    <= '0;
            out_im_reg    <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_INVERSE_MODE: inverse_reg <= cfg_data[0];
                    REG_LOG2_POINTS:  log2_reg    <= cfg_data;
                    default:          ;
                endcase
            end
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];

            case (state_reg)
                S_LOAD:
                begin
                    if (accept_in)
                    begin
                        if (cnt_reg < n_cur)
                        begin
                            cnt_reg <= cnt_reg + CNT_BITS'(1);
                        end
                        if (s_tlast)
                        begin
                            lg_reg    <= eff_lg;
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    if (cnt_reg < n_run)
                    begin
                        cnt_reg <= cnt_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        stage_reg <= LG_BITS'(1);
                        bf_reg    <= '0;
                        state_reg <= S_RDB;
                    end
                end
                S_RDB: state_reg <= S_RDA;
                S_RDA: state_reg <= S_M0;
                S_M0:  state_reg <= S_M1;
                S_M1:  state_reg <= S_M2;
                S_M2:  state_reg <= S_M3;
                S_M3:  state_reg <= S_M4;
                S_M4:  state_reg <= S_WA;
                S_WA:  state_reg <= S_WB;
                S_WB:
                begin
                    if (!last_bf)
                    begin
                        bf_reg    <= bf_reg + (ADDR_BITS-1)'(1);
                        state_reg <= S_RDB;
                    end
                    else if (stage_reg != lg_reg)
                    begin
                        bf_reg    <= '0;
                        stage_reg <= stage_reg + LG_BITS'(1);
                        state_reg <= S_RDB;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        state_reg <= S_ORD;
                    end
                end
                S_ORD: state_reg <= S_OCAP;
                S_OCAP:
                begin
                    out_valid_reg <= 1'b1;
                    out_re_reg    <= inverse_reg ? bin_t'(scale_re) : rd_re;
                    out_im_reg    <= inverse_reg ? bin_t'(scale_im) : rd_im;
                    out_idx_reg   <= k_reg;
                    out_last_reg  <= (CNT_BITS'(k_reg) == n_run - CNT_BITS'(1));
                    state_reg     <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    if (accept_out)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + ADDR_BITS'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_idx_reg, out_im_reg, out_re_reg};

endmodule

/* design/r2fft_chk.sv */
// Port-level checker for the radix-2 FFT, bound to the top level.
`include "radix2_fft_assert.svh"

module r2fft_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // The block never loads samples while a bin is on offer.
    `R2FFT_NEVER(a_no_load_while_out, s_tready && m_tvalid, "input ready while a bin waits")

    // A stalled bin keeps its contents.
    `R2FFT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "bin changed while stalled")

    // After the last bin is taken the block returns to loading.
    `R2FFT_ASSERT(a_last_done, m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready, "no return to load after last bin")

    // Once a bin other than the last is taken, the next bin follows with the next index.
    `R2FFT_ASSERT(a_next_index, m_tvalid && m_tready && !m_tlast |=> !m_tvalid ##1 !m_tvalid ##1 m_tvalid && m_tdata[51:46] == $past(m_tdata[51:46], 3) + 6'd1, "bad bin index")

endmodule

bind radix2_fft r2fft_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
